>>> sv/mda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mda_pkg: shared types and constants for the multidimensional array core
// Item layouts, status codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mda_pkg;

  // Fixed field widths
  localparam int NUM_IDX      = 4;
  localparam int MAX_DIMS     = 4;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_W        = 16;
  localparam int SIZE_W       = 13;
  localparam int CNT_W        = 3;
  localparam int STEP_W       = $clog2(NUM_IDX);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  // Default store depth for the top level
  localparam int STORE_DEPTH_DEF = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM3 = 3'd4;

  // Operation kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_INDEX = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_RANGE    = 3'd3,
    ST_BEYOND   = 3'd4
  } status_t;

  // Input item
  typedef struct packed {
    logic                    kind;
    logic [CNT_W-1:0]        index_count;
    logic signed [IDX_W-1:0] index0;
    logic signed [IDX_W-1:0] index1;
    logic signed [IDX_W-1:0] index2;
    logic signed [IDX_W-1:0] index3;
    logic [DATA_WIDTH-1:0]   write_word;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_word;
    status_t               status;
    logic [CNT_W-1:0]      bad_dimension;
  } out_item_t;

  // Classified operation passed from front to back (address travels beside it)
  typedef struct packed {
    logic                  kind;
    status_t               status;
    logic [CNT_W-1:0]      bad_dimension;
    logic [DATA_WIDTH-1:0] write_word;
  } op_t;

endpackage
`default_nettype wire

>>> sv/multidim_array_access_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multidim_array_access_core: row-major multidimensional array store
// Flow: an accepted item is checked, then gets one multiply-add per index up to
//   the last or an overrun unless its count or range is rejected, then is queued.
// Intake: a new item is taken only once the last one is handed to the queue.
// Reset: a clearing pass zeroes the store; busy stays high meanwhile,
//   configuration writes are taken. Results cannot be stalled.
// ----------------------------------------------------------------------------
module multidim_array_access_core #(
  parameter int STORE_DEPTH = mda_pkg::STORE_DEPTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  mda_pkg::in_item_t             in_item,
  output logic                          out_strobe,
  output mda_pkg::out_item_t            out_item,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [mda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mda_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mda_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QW = $bits(op_t) + AW;

  logic          clearing;
  logic          f_push_valid;
  logic          f_push_ready;
  op_t           f_op;
  logic [AW-1:0] f_addr;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;
  op_t           q_op;
  logic [AW-1:0] q_addr;

  assign cfg_ready = 1'b1;

  // Front: intake, checks, address
  mda_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .clearing   (clearing),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_op    (f_op),
    .push_addr  (f_addr)
  );

  // Queue between front and back
  mda_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_data  ({f_op, f_addr}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_op   = q_data[QW-1:AW];
  assign q_addr = q_data[AW-1:0];

  // Back: store access and result
  mda_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_op       (q_op),
    .q_addr     (q_addr),
    .clearing   (clearing),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTHESIS
  // No result while the store is being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_strobe)
    else $error("result during clearing pass");

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // Failed accesses return zero data
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_OK)) |-> (out_item.read_word == '0))
    else $error("nonzero data on failed access");

  // A failing dimension is reported exactly for range errors
  a_bad_dim_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_item.status == ST_RANGE) == (out_item.bad_dimension != '0)))
    else $error("bad dimension does not match status");
`endif

endmodule
`default_nettype wire

>>> sv/mda_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mda_front: item intake, bounds checks and row-major address formation
// Holds the configuration registers, classifies each item and builds the
// linear address with one multiply-add per dimension, then hands it on.
// ----------------------------------------------------------------------------
module mda_front #(
  parameter int STORE_DEPTH = mda_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  mda_pkg::in_item_t               in_item,
  output logic                            busy,
  input  wire                             clearing,
  input  wire                             cfg_valid,
  input  wire [mda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mda_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                            push_valid,
  input  wire                             push_ready,
  output mda_pkg::op_t                    push_op,
  output logic [AW-1:0]                   push_addr
);
  import mda_pkg::*;

  localparam int SW = AW + SIZE_W + 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } fstate_t;

  fstate_t                 state_r;
  in_item_t                item_r;
  logic [STEP_W-1:0]       step_r;
  logic [AW-1:0]           acc_r;
  op_t                     op_r;
  logic [AW-1:0]           addr_r;
  logic [CNT_W-1:0]        dim_count_r;
  logic [SIZE_W-1:0]       size_r [NUM_IDX];

  logic signed [IDX_W-1:0] idx [NUM_IDX];
  logic [NUM_IDX-1:0]      fail;
  status_t                 cls_status;
  logic [CNT_W-1:0]        cls_bad;
  logic [SW-1:0]           sum_nxt;
  logic                    over;
  logic                    last;
  logic                    accept;

  assign accept     = start && !busy;
  assign busy       = (state_r != F_IDLE) || clearing;
  assign push_valid = (state_r == F_PUSH);
  assign push_op    = op_r;
  assign push_addr  = addr_r;

  assign idx[0] = item_r.index0;
  assign idx[1] = item_r.index1;
  assign idx[2] = item_r.index2;
  assign idx[3] = item_r.index3;

  // Check each index against its extent; negative indexes always fail
  always_comb begin
    for (int i = 0; i < NUM_IDX; i++) begin
      fail[i] = idx[i][IDX_W-1] ||
                ({1'b0, idx[i][IDX_W-2:0]} >= {{(IDX_W-SIZE_W){1'b0}}, size_r[i]});
    end
  end

  // Classify the count, then report the highest failing given dimension
  always_comb begin
    cls_status = ST_OK;
    cls_bad    = '0;
    if (item_r.index_count == '0) begin
      cls_status = ST_NO_INDEX;
    end else if ((item_r.index_count > dim_count_r) ||
                 (int'(item_r.index_count) > MAX_DIMS) ||
                 (int'(item_r.index_count) > NUM_IDX)) begin
      cls_status = ST_TOO_MANY;
    end else begin
      for (int i = 0; i < NUM_IDX; i++) begin
        if ((CNT_W'(i) < item_r.index_count) && fail[i]) begin
          cls_status = ST_RANGE;
          cls_bad    = CNT_W'(i + 1);
        end
      end
    end
  end

  // One Horner step: acc * extent + index
  always_comb begin
    sum_nxt = SW'(acc_r) * SW'(size_r[step_r]) + SW'(idx[step_r][IDX_W-2:0]);
    over    = (sum_nxt >= SW'(STORE_DEPTH));
    last    = ((CNT_W'(step_r) + CNT_W'(1)) == item_r.index_count);
  end

  // Accept, iterate over dimensions, hand the operation to the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      dim_count_r <= CNT_W'(1);
      for (int i = 0; i < NUM_IDX; i++) begin
        size_r[i] <= SIZE_W'(1);
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DIM_COUNT: dim_count_r <= cfg_data[CNT_W-1:0];
          CFG_SIZE_DIM0: size_r[0]   <= cfg_data[SIZE_W-1:0];
          CFG_SIZE_DIM1: size_r[1]   <= cfg_data[SIZE_W-1:0];
          CFG_SIZE_DIM2: size_r[2]   <= cfg_data[SIZE_W-1:0];
          CFG_SIZE_DIM3: size_r[3]   <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            item_r  <= in_item;
            step_r  <= '0;
            acc_r   <= '0;
            state_r <= F_CALC;
          end
        end
        F_CALC: begin
          op_r.kind          <= item_r.kind;
          op_r.write_word    <= item_r.write_word;
          op_r.bad_dimension <= cls_bad;
          if (cls_status != ST_OK) begin
            op_r.status <= cls_status;
            state_r     <= F_PUSH;
          end else if (over) begin
            op_r.status <= ST_BEYOND;
            state_r     <= F_PUSH;
          end else if (last) begin
            op_r.status <= ST_OK;
            addr_r      <= sum_nxt[AW-1:0];
            state_r     <= F_PUSH;
          end else begin
            acc_r  <= sum_nxt[AW-1:0];
            step_r <= step_r + STEP_W'(1);
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mda_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mda_queue: short operation queue between front and back
// Two-entry register queue; each side moves on its own handshake.
// ----------------------------------------------------------------------------
module mda_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push_valid,
  output logic         push_ready,
  input  wire  [W-1:0] push_data,
  output logic         pop_valid,
  input  wire          pop_ready,
  output logic [W-1:0] pop_data
);
  import mda_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  logic [W-1:0]  ent_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != CW'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      priority if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mda_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mda_back: element store access and result delivery
// Clears the store after reset, then performs one read or write per
// operation and presents the result for one cycle.
// ----------------------------------------------------------------------------
module mda_back #(
  parameter int STORE_DEPTH = mda_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  output logic               q_ready,
  input  mda_pkg::op_t       q_op,
  input  wire  [AW-1:0]      q_addr,
  output logic               clearing,
  output logic               out_strobe,
  output mda_pkg::out_item_t out_item
);
  import mda_pkg::*;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
  logic                  clr_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  strobe_r;
  status_t               status_r;
  logic [CNT_W-1:0]      bad_r;
  logic                  rd_ok_r;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  pop;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;

  assign q_ready  = !clr_r;
  assign clearing = clr_r;
  assign pop      = q_valid && !clr_r;

  // Select the write port: clearing sweep or a checked write
  always_comb begin
    we    = clr_r || (pop && (q_op.status == ST_OK) && (q_op.kind == KIND_WRITE));
    waddr = clr_r ? clr_addr_r : q_addr;
    wdata = clr_r ? '0 : q_op.write_word;
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[q_addr];
  end

  // Sweep after reset, then register result metadata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      strobe_r <= pop;
      if (pop) begin
        status_r <= q_op.status;
        bad_r    <= q_op.bad_dimension;
        rd_ok_r  <= (q_op.status == ST_OK) && (q_op.kind == KIND_READ);
      end
    end
  end

  assign out_strobe             = strobe_r;
  assign out_item.read_word     = rd_ok_r ? rd_data_r : '0;
  assign out_item.status        = status_r;
  assign out_item.bad_dimension = bad_r;

endmodule
`default_nettype wire

>>> dv/multidim_array_access_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidim_array_access_core_test: self-checking bench for the array core
// Drives read and write items over the start/busy port and keeps a shadow
// copy of the element store and registers. The expected result of each
// accepted item is queued and compared field by field with each strobed
// result. Directed checks of counts, bounds and address limits come first,
// then random traffic over many register settings and sender idle rates.
// ----------------------------------------------------------------------------
module multidim_array_access_core_test;
  import mda_pkg::*;

  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int DEPTH_AW    = $clog2(DEPTH);
  localparam int SETTINGS_PP = 13;   // register settings per random phase
  localparam int ITEMS_PS    = 50;   // items per register setting

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow of the block's registers and element store
  logic [CNT_W-1:0]      dims_cfg;
  logic [SIZE_W-1:0]     extent_cfg [NUM_IDX];
  logic [DATA_WIDTH-1:0] shadow_store [DEPTH];

  out_item_t pending_results [$];
  int        idle_pct;
  int        items_sent;
  int        results_checked;
  int        settings_applied;
  int        err_count;

  multidim_array_access_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Timeout at %0t with %0d results outstanding", $time, pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Work out one access against the shadow store; a good write updates it
  function automatic out_item_t resolve_access(input in_item_t it);
    out_item_t         r;
    logic [IDX_W-1:0]  ix [NUM_IDX];
    longint unsigned   addr;
    longint unsigned   stride;
    int                cnt;
    r.read_word     = '0;
    r.status        = ST_OK;
    r.bad_dimension = '0;
    ix[0] = it.index0;
    ix[1] = it.index1;
    ix[2] = it.index2;
    ix[3] = it.index3;
    cnt   = it.index_count;
    addr   = 0;
    stride = 1;
    if (cnt == 0) begin
      r.status = ST_NO_INDEX;
    end else if (cnt > dims_cfg || cnt > MAX_DIMS) begin
      r.status = ST_TOO_MANY;
    end else begin
      // Check last index first; stop accumulating at the first failure
      for (int i = cnt - 1; i >= 0; i--) begin
        if (r.status == ST_OK) begin
          if (ix[i][IDX_W-1] || ix[i] >= extent_cfg[i]) begin
            r.status        = ST_RANGE;
            r.bad_dimension = CNT_W'(i + 1);
          end else begin
            addr   = addr + ix[i] * stride;
            stride = stride * extent_cfg[i];
          end
        end
      end
      if (r.status == ST_OK) begin
        if (addr >= DEPTH) begin
          r.status = ST_BEYOND;
        end else if (it.kind == KIND_WRITE) begin
          shadow_store[addr[DEPTH_AW-1:0]] = it.write_word;
        end else begin
          r.read_word = shadow_store[addr[DEPTH_AW-1:0]];
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t mk_access(input logic kind, input logic [CNT_W-1:0] cnt,
                                         input logic [IDX_W-1:0] i0, input logic [IDX_W-1:0] i1,
                                         input logic [IDX_W-1:0] i2, input logic [IDX_W-1:0] i3,
                                         input logic [DATA_WIDTH-1:0] word);
    in_item_t it;
    it.kind        = kind;
    it.index_count = cnt;
    it.index0      = i0;
    it.index1      = i1;
    it.index2      = i2;
    it.index3      = i3;
    it.write_word  = word;
    return it;
  endfunction

  // Mostly in range for the extent, otherwise negative, edge or junk
  function automatic logic [IDX_W-1:0] random_index(input logic [SIZE_W-1:0] extent);
    if (extent != 0 && $urandom_range(99) < 85)
      return IDX_W'($urandom_range(extent - 1, 0));
    case ($urandom_range(3))
      0:       return IDX_W'($urandom);
      1:       return extent;
      2:       return 16'hFFFF;
      default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  function automatic in_item_t random_access();
    in_item_t it;
    int       cnt_max;
    cnt_max = (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
    it.kind = 1'($urandom_range(1));
    if (cnt_max != 0 && $urandom_range(99) < 85)
      it.index_count = CNT_W'($urandom_range(cnt_max, 1));
    else
      it.index_count = CNT_W'($urandom_range(7));
    it.index0     = random_index(extent_cfg[0]);
    it.index1     = random_index(extent_cfg[1]);
    it.index2     = random_index(extent_cfg[2]);
    it.index3     = random_index(extent_cfg[3]);
    it.write_word = $urandom;
    return it;
  endfunction

  // Offer one item after random idle cycles; hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(resolve_access(it));
    items_sent++;
  endtask

  // Hold off the sender until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_valid high so writes can go back to back
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DIM_COUNT: dims_cfg      = val[CNT_W-1:0];
      CFG_SIZE_DIM0: extent_cfg[0] = val;
      CFG_SIZE_DIM1: extent_cfg[1] = val;
      CFG_SIZE_DIM2: extent_cfg[2] = val;
      CFG_SIZE_DIM3: extent_cfg[3] = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] dims,
                               input logic [CFG_DATA_W-1:0] e0, input logic [CFG_DATA_W-1:0] e1,
                               input logic [CFG_DATA_W-1:0] e2, input logic [CFG_DATA_W-1:0] e3);
    drain_results();
    write_register(CFG_DIM_COUNT, dims);
    write_register(CFG_SIZE_DIM0, e0);
    write_register(CFG_SIZE_DIM1, e1);
    write_register(CFG_SIZE_DIM2, e2);
    write_register(CFG_SIZE_DIM3, e3);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_item.read_word !== want.read_word) begin
          $display("%0t: read_word mismatch, expected %h, got %h",
                   $time, want.read_word, out_item.read_word);
          err_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_item.status);
          err_count++;
        end
        if (out_item.bad_dimension !== want.bad_dimension) begin
          $display("%0t: bad_dimension mismatch, expected %0d, got %0d",
                   $time, want.bad_dimension, out_item.bad_dimension);
          err_count++;
        end
      end
    end
  end

  // Store cleared at reset, default one-dimensional array of one element
  task automatic test_reset_state();
    send_item(mk_access(KIND_READ,  1, 0, 0, 0, 0, 0));
    send_item(mk_access(KIND_WRITE, 1, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(mk_access(KIND_READ,  1, 0, 0, 0, 0, 0));
    send_item(mk_access(KIND_READ,  1, 1, 0, 0, 0, 0));
  endtask

  // Zero count, count above dim_count and above the index fields
  task automatic test_index_count();
    apply_setting(4, 4, 5, 6, 7);
    send_item(mk_access(KIND_READ,  0, 0, 0, 0, 0, 0));
    send_item(mk_access(KIND_WRITE, 5, 0, 0, 0, 0, 32'h1234_5678));
    send_item(mk_access(KIND_READ,  7, 0, 0, 0, 0, 0));
    send_item(mk_access(KIND_READ,  4, 0, 0, 0, 0, 0));
  endtask

  // Negative and oversize indexes, last index checked first, partial counts
  task automatic test_index_range();
    send_item(mk_access(KIND_READ,  1, 16'hFFFF, 0, 0, 0, 0));
    send_item(mk_access(KIND_WRITE, 1, 16'h8000, 0, 0, 0, 32'hDEAD_BEEF));
    send_item(mk_access(KIND_READ,  4, 4, 0, 0, 7, 0));
    send_item(mk_access(KIND_READ,  3, 0, 16'h7FFF, 6, 0, 0));
    send_item(mk_access(KIND_WRITE, 4, 3, 4, 5, 6, 32'hA5A5_5A5A));
    send_item(mk_access(KIND_READ,  4, 3, 4, 5, 6, 0));
    send_item(mk_access(KIND_WRITE, 2, 3, 4, 16'hFFFF, 16'h8000, 32'h0000_0000));
    send_item(mk_access(KIND_READ,  2, 3, 4, 0, 0, 0));
  endtask

  // Largest extents, addresses past the store, a zero extent
  task automatic test_address_limits();
    apply_setting(4, 4096, 4096, 4096, 4096);
    send_item(mk_access(KIND_WRITE, 2, 1, 0, 0, 0, 32'h5555_AAAA));
    send_item(mk_access(KIND_WRITE, 1, 4095, 0, 0, 0, 32'h0F0F_F0F0));
    send_item(mk_access(KIND_READ,  1, 4095, 0, 0, 0, 0));
    apply_setting(1, 0, 8191, 8191, 8191);
    send_item(mk_access(KIND_READ,  1, 0, 0, 0, 0, 0));
    apply_setting(2, 8191, 8191, 1, 1);
    send_item(mk_access(KIND_READ,  1, 4096, 0, 0, 0, 0));
    send_item(mk_access(KIND_READ,  2, 0, 8190, 0, 0, 0));
  endtask

  // dim_count of zero and above MAX_DIMS, and a write to an unused index
  task automatic test_register_limits();
    apply_setting(0, 2, 2, 2, 2);
    send_item(mk_access(KIND_READ, 1, 0, 0, 0, 0, 0));
    apply_setting(7, 2, 2, 2, 2);
    drain_results();
    write_register(3'd7, 13'h1FFF);
    cfg_valid <= 1'b0;
    send_item(mk_access(KIND_READ,  5, 0, 0, 0, 0, 0));
    send_item(mk_access(KIND_WRITE, 4, 1, 1, 1, 1, 32'hC3C3_3C3C));
  endtask

  // Random items over a run of register settings, extremes first
  task automatic test_random_traffic(input int pct);
    idle_pct = pct;
    for (int s = 0; s < SETTINGS_PP; s++) begin
      case (s)
        0: apply_setting(4, 8, 8, 8, 8);
        1: apply_setting(1, 4096, CFG_DATA_W'($urandom_range(8)), 1, 1);
        2: apply_setting(2, 8191, 8191, CFG_DATA_W'($urandom_range(8191)), 0);
        3: apply_setting(0, CFG_DATA_W'($urandom_range(8, 1)), 3, 3, 3);
        4: apply_setting(CFG_DATA_W'($urandom_range(7, 5)), CFG_DATA_W'($urandom_range(8, 1)),
                         CFG_DATA_W'($urandom_range(8, 1)), CFG_DATA_W'($urandom_range(8, 1)),
                         CFG_DATA_W'($urandom_range(8, 1)));
        5: apply_setting(3, CFG_DATA_W'($urandom_range(8, 1)), 0,
                         CFG_DATA_W'($urandom_range(8, 1)), 5);
        6: apply_setting(4, 1, 1, 1, 1);
        default: apply_setting(CFG_DATA_W'($urandom_range(4, 1)),
                               ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(8191))
                                                        : CFG_DATA_W'($urandom_range(8, 1)),
                               CFG_DATA_W'($urandom_range(8, 1)),
                               CFG_DATA_W'($urandom_range(8, 1)),
                               CFG_DATA_W'($urandom_range(8, 1)));
      endcase
      repeat (ITEMS_PS) send_item(random_access());
    end
  endtask

  initial begin
    dims_cfg = 1;
    foreach (extent_cfg[i]) extent_cfg[i] = 1;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    idle_pct         = 10;
    items_sent       = 0;
    results_checked  = 0;
    settings_applied = 0;
    err_count        = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_index_count();
    test_index_range();
    test_address_limits();
    test_register_limits();
    test_random_traffic(10);
    test_random_traffic(75);
    test_random_traffic(0);

    // Let the last results come back, then allow the pipeline to settle
    drain_results();
    repeat (16) @(posedge clk);

    $display("Sent %0d items over %0d register settings; %0d results checked, %0d mismatches",
             items_sent, settings_applied, results_checked, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
